// ===== rtl/wsd_pkg.sv =====
// Shared types, result codes and helpers for the WebSocket frame deframer.
// No dependencies; the parser, the result queue and the top level refer to this package.
package wsd_pkg;

    localparam int FIFO_DEPTH = 4;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [2:0] ERR_SHORT_HEADER  = 3'd0;
    localparam logic [2:0] ERR_SHORT_EXT16   = 3'd1;
    localparam logic [2:0] ERR_SHORT_EXT64   = 3'd2;
    localparam logic [2:0] ERR_SHORT_KEY     = 3'd3;
    localparam logic [2:0] ERR_SHORT_PAYLOAD = 3'd4;
    localparam logic [2:0] ERR_BAD_LENGTH    = 3'd5;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic        fin_bit;
        logic [2:0]  reserved_bits;
        logic [3:0]  frame_opcode;
        logic        mask_present;
        logic [62:0] frame_length;
        logic [31:0] masking_key;
        logic [7:0]  payload_byte;
        logic [2:0]  error_code;
        logic        frame_end;
    } t_result;

    // Results produced by one accepted byte: zero, one or two of them.
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

    function automatic t_result error_result(input logic [2:0] code);
        t_result r;
        r            = '0;
        r.result_kind = KIND_ERROR;
        r.error_code  = code;
        r.frame_end   = 1'b1;
        return r;
    endfunction

endpackage

// ===== rtl/wsd_byte_if.sv =====
// Byte input channel of the frame deframer: valid/ready plus one buffer byte.
// No dependencies.
interface wsd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       buffer_end;

    modport source(output valid, output data_byte, output buffer_end, input ready);
    modport sink(input valid, input data_byte, input buffer_end, output ready);
endinterface

// ===== rtl/wsd_result_if.sv =====
// Result output channel of the frame deframer: valid/ready plus one result item.
// No dependencies.
interface wsd_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic        fin_bit;
    logic [2:0]  reserved_bits;
    logic [3:0]  frame_opcode;
    logic        mask_present;
    logic [62:0] frame_length;
    logic [31:0] masking_key;
    logic [7:0]  payload_byte;
    logic [2:0]  error_code;
    logic        frame_end;

    modport source(output valid, output result_kind, output fin_bit, output reserved_bits,
                   output frame_opcode, output mask_present, output frame_length,
                   output masking_key, output payload_byte, output error_code,
                   output frame_end, input ready);
    modport sink(input valid, input result_kind, input fin_bit, input reserved_bits,
                 input frame_opcode, input mask_present, input frame_length,
                 input masking_key, input payload_byte, input error_code,
                 input frame_end, output ready);
endinterface

// ===== rtl/wsd_parser.sv =====
// Header parser and payload unmasker: holds the frame state and builds the
// results of one accepted byte. Depends on wsd_pkg.
module wsd_parser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_data_byte,
    input  logic           i_buffer_end,
    output wsd_pkg::t_push o_push
);

    localparam logic [2:0] PH_HDR1    = 3'd0;
    localparam logic [2:0] PH_HDR2    = 3'd1;
    localparam logic [2:0] PH_EXT16   = 3'd2;
    localparam logic [2:0] PH_EXT64   = 3'd3;
    localparam logic [2:0] PH_KEY     = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;
    localparam logic [2:0] PH_DISCARD = 3'd6;

    logic [2:0]  r_phase,  n_phase;
    logic [8:0]  r_hdr,    n_hdr;
    logic [63:0] r_len,    n_len;
    logic [3:0]  r_cnt,    n_cnt;
    logic [31:0] r_key,    n_key;
    logic [62:0] r_remain, n_remain;
    logic [1:0]  r_kidx,   n_kidx;

    logic        known_go;
    logic        hdr_go;
    logic        err_go;
    logic        err_last;
    logic [2:0]  err_code;
    logic [6:0]  len7;
    logic [7:0]  key_byte;
    logic        last;

    always_comb begin
        n_phase  = r_phase;
        n_hdr    = r_hdr;
        n_len    = r_len;
        n_cnt    = r_cnt;
        n_key    = r_key;
        n_remain = r_remain;
        n_kidx   = r_kidx;
        known_go = 1'b0;
        hdr_go   = 1'b0;
        err_go   = 1'b0;
        err_last = 1'b1;
        err_code = wsd_pkg::ERR_SHORT_HEADER;
        o_push   = '0;
        last     = i_buffer_end;
        len7     = i_data_byte[6:0];
        unique case (r_kidx)
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase

        unique case (r_phase)
            PH_HDR1: begin
                n_hdr    = {1'b0, i_data_byte};
                n_len    = '0;
                n_cnt    = '0;
                n_key    = '0;
                n_remain = '0;
                n_kidx   = '0;
                if (last) begin
                    err_go   = 1'b1;
                    err_code = wsd_pkg::ERR_SHORT_HEADER;
                end else begin
                    n_phase = PH_HDR2;
                end
            end
            PH_HDR2: begin
                n_hdr = {i_data_byte[7], r_hdr[7:0]};
                n_cnt = '0;
                n_len = '0;
                if (len7 == 7'd126) begin
                    n_phase  = PH_EXT16;
                    err_go   = last;
                    err_code = wsd_pkg::ERR_SHORT_EXT16;
                end else if (len7 == 7'd127) begin
                    n_phase  = PH_EXT64;
                    err_go   = last;
                    err_code = wsd_pkg::ERR_SHORT_EXT64;
                end else begin
                    n_len    = 64'(len7);
                    known_go = 1'b1;
                end
            end
            PH_EXT16: begin
                n_len = {48'd0, r_len[7:0], i_data_byte};
                n_cnt = r_cnt + 4'd1;
                if (n_cnt >= 4'd2) begin
                    known_go = 1'b1;
                end else begin
                    err_go   = last;
                    err_code = wsd_pkg::ERR_SHORT_EXT16;
                end
            end
            PH_EXT64: begin
                n_len = {r_len[55:0], i_data_byte};
                n_cnt = r_cnt + 4'd1;
                if (n_cnt >= 4'd8) begin
                    if (n_len[63]) begin
                        // Lengths with the top bit set are illegal; the rest
                        // of the buffer is dropped unless this was its end.
                        err_go   = 1'b1;
                        err_last = last;
                        err_code = wsd_pkg::ERR_BAD_LENGTH;
                    end else begin
                        known_go = 1'b1;
                    end
                end else begin
                    err_go   = last;
                    err_code = wsd_pkg::ERR_SHORT_EXT64;
                end
            end
            PH_KEY: begin
                n_key = {r_key[23:0], i_data_byte};
                n_cnt = r_cnt + 4'd1;
                if (n_cnt >= 4'd4) begin
                    hdr_go = 1'b1;
                end else begin
                    err_go   = last;
                    err_code = wsd_pkg::ERR_SHORT_KEY;
                end
            end
            PH_PAYLOAD: begin
                o_push.count              = 2'd1;
                o_push.first.result_kind  = wsd_pkg::KIND_PAYLOAD;
                o_push.first.payload_byte = i_data_byte ^ key_byte;
                n_kidx   = r_kidx + 2'd1;
                n_remain = r_remain - 63'd1;
                if (r_remain == 63'd1) begin
                    o_push.first.frame_end = 1'b1;
                    n_phase = last ? PH_HDR1 : PH_DISCARD;
                end else begin
                    err_go   = last;
                    err_code = wsd_pkg::ERR_SHORT_PAYLOAD;
                end
            end
            default: begin
                n_phase = last ? PH_HDR1 : PH_DISCARD;
            end
        endcase

        // Length fully decoded: either collect the key or finish the header.
        if (known_go) begin
            n_remain = n_len[62:0];
            if (n_hdr[8]) begin
                n_phase  = PH_KEY;
                n_cnt    = '0;
                err_go   = last;
                err_code = wsd_pkg::ERR_SHORT_KEY;
            end else begin
                hdr_go = 1'b1;
            end
        end

        if (hdr_go) begin
            o_push.count                = 2'd1;
            o_push.first.result_kind    = wsd_pkg::KIND_HEADER;
            o_push.first.fin_bit        = n_hdr[7];
            o_push.first.reserved_bits  = n_hdr[6:4];
            o_push.first.frame_opcode   = n_hdr[3:0];
            o_push.first.mask_present   = n_hdr[8];
            o_push.first.frame_length   = n_remain;
            o_push.first.masking_key    = n_key;
            if (n_remain == '0) begin
                o_push.first.frame_end = 1'b1;
                n_phase = last ? PH_HDR1 : PH_DISCARD;
            end else begin
                n_phase  = PH_PAYLOAD;
                n_kidx   = '0;
                err_go   = last;
                err_code = wsd_pkg::ERR_SHORT_PAYLOAD;
            end
        end

        // An error always closes the frame and lands after any earlier result.
        if (err_go) begin
            n_phase = err_last ? PH_HDR1 : PH_DISCARD;
            if (o_push.count == 2'd0) begin
                o_push.first = wsd_pkg::error_result(err_code);
                o_push.count = 2'd1;
            end else begin
                o_push.second = wsd_pkg::error_result(err_code);
                o_push.count  = 2'd2;
            end
        end

        if (!i_accept) begin
            o_push.count = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR1;
            r_hdr    <= '0;
            r_len    <= '0;
            r_cnt    <= '0;
            r_key    <= '0;
            r_remain <= '0;
            r_kidx   <= '0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_hdr    <= n_hdr;
            r_len    <= n_len;
            r_cnt    <= n_cnt;
            r_key    <= n_key;
            r_remain <= n_remain;
            r_kidx   <= n_kidx;
        end
    end

endmodule

// ===== rtl/wsd_result_fifo.sv =====
// Small result queue: takes up to two results per cycle, hands out one.
// Depends on wsd_pkg.
module wsd_result_fifo #(
    parameter int P_DEPTH = wsd_pkg::FIFO_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  wsd_pkg::t_push               i_push,
    input  logic                         i_pop,
    output wsd_pkg::t_result             o_head,
    output logic [$clog2(P_DEPTH+1)-1:0] o_level
);

    localparam int AW = $clog2(P_DEPTH);
    localparam int CW = $clog2(P_DEPTH + 1);

    wsd_pkg::t_result r_mem [P_DEPTH];
    logic [AW-1:0]    r_wr, n_wr;
    logic [AW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_count, n_count;
    logic [AW-1:0]    wr_next;

    assign wr_next = r_wr + AW'(1);
    assign o_head  = r_mem[r_rd];
    assign o_level = r_count;

    always_comb begin
        n_wr    = r_wr + AW'(i_push.count);
        n_rd    = i_pop ? r_rd + AW'(1) : r_rd;
        n_count = r_count + CW'(i_push.count) - CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_next] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

// ===== rtl/websocket_frame_deframer_unit.sv =====
// Top level of the WebSocket frame deframer: parser plus result queue.
// Depends on wsd_pkg, wsd_byte_if, wsd_result_if, wsd_parser, wsd_result_fifo.
//
//  Channel    Dir  Payload                                   Handshake
//  i_byte     in   data_byte[7:0], buffer_end                valid/ready
//  o_result   out  result_kind, header fields, payload_byte, valid/ready
//                  error_code, frame_end
//
// Each accepted byte is parsed in the cycle it is taken: the frame state
// registers update at that edge and the zero, one or two results it causes
// are written into a small result queue, so a byte can be taken every cycle
// that it has room. Results are held in the queue and reach o_result in order.
// The input is ready while the queue has room for two more results; when the
// output is stalled, bytes keep flowing until fewer than two slots are free.
// Reset (synchronous, active low) returns the parser to waiting for the first
// header byte and empties the queue.
module websocket_frame_deframer_unit #(
    parameter int P_FIFO_DEPTH = wsd_pkg::FIFO_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    wsd_byte_if.sink            i_byte,
    wsd_result_if.source        o_result
);

    localparam int CW = $clog2(P_FIFO_DEPTH + 1);

    logic             accept;
    logic             pop;
    wsd_pkg::t_push   push;
    wsd_pkg::t_result head;
    logic [CW-1:0]    level;

    // One byte may produce two results, so keep two slots in reserve.
    assign i_byte.ready = (level <= CW'(P_FIFO_DEPTH - 2));
    assign accept       = i_byte.valid & i_byte.ready;
    assign pop          = o_result.valid & o_result.ready;

    wsd_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_data_byte  (i_byte.data_byte),
        .i_buffer_end (i_byte.buffer_end),
        .o_push       (push)
    );

    wsd_result_fifo #(
        .P_DEPTH (P_FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_level (level)
    );

    // The head of the queue drives the output channel directly.
    assign o_result.valid          = (level != '0);
    assign o_result.result_kind    = head.result_kind;
    assign o_result.fin_bit        = head.fin_bit;
    assign o_result.reserved_bits  = head.reserved_bits;
    assign o_result.frame_opcode   = head.frame_opcode;
    assign o_result.mask_present   = head.mask_present;
    assign o_result.frame_length   = head.frame_length;
    assign o_result.masking_key    = head.masking_key;
    assign o_result.payload_byte   = head.payload_byte;
    assign o_result.error_code     = head.error_code;
    assign o_result.frame_end      = head.frame_end;

    // A byte that produced results must make the output valid next cycle.
    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && push.count != 2'd0) |=> o_result.valid)
        else $error("results of an accepted byte did not reach the output");

    // The queue never holds more than its depth.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        level <= CW'(P_FIFO_DEPTH))
        else $error("result queue overflow");

    // Every error closes its frame.
    a_error_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.result_kind == wsd_pkg::KIND_ERROR)
        |-> o_result.frame_end)
        else $error("error result without frame_end");

    // A header of an empty frame is the frame's last result.
    a_empty_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.result_kind == wsd_pkg::KIND_HEADER
         && o_result.frame_length == '0) |-> o_result.frame_end)
        else $error("zero-length header without frame_end");

endmodule
